[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types of the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    localparam int VALUE_W       = 32;
    localparam int COUNT_OUT_W   = 5;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic push;
        logic pop;
        logic reject;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } t_status;

endpackage

[hw/rtl/sorted_priority_queue.sv]
// After an item is accepted, the controller enters its load state, where the result
// register is loaded once no older result still waits at the output.
// The controller takes a new item only in its idle state: it updates the sorted cells
// on accept and does not take another item before the result register is loaded.
// Reset (i_rst_n low, synchronous) empties the queue and drops any result;
// stored values are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded queue kept in ascending order with push and pop-smallest items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_kind,
    input  spq_pkg::t_value                 i_new_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output spq_pkg::t_value                 o_head_value,
    output spq_pkg::t_value                 o_tail_value,
    output logic [spq_pkg::COUNT_OUT_W-1:0] o_entry_count,
    output logic                            o_is_empty,
    output logic                            o_rejected
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          cmd;
    t_status       status;
    logic [CW-1:0] count;
    logic          empty_marked;
    logic          head_le_tail;
    logic          filled_result;

    spq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_kind   (i_kind),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_new_value   (i_new_value),
        .o_status      (status),
        .o_count       (count),
        .o_head_value  (o_head_value),
        .o_tail_value  (o_tail_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_rejected    (o_rejected)
    );

    assign empty_marked  = (o_head_value == '1) && (o_tail_value == '1) &&
                           (o_entry_count == '0);
    assign head_le_tail  = (o_head_value <= o_tail_value);
    assign filled_result = o_valid && !o_is_empty;

    `ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, count <= CW'(DEPTH), "count above depth")
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "item overlap")
    `ASSERT_IMP(a_empty_marks, i_clk, i_rst_n, o_valid && o_is_empty, empty_marked, "empty unmarked")
    `ASSERT_IMP(a_head_le_tail, i_clk, i_rst_n, filled_result, head_le_tail, "head above tail")

endmodule

[hw/rtl/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// Two-state controller: updates the queue on accept, then loads the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_kind,
    output logic            o_valid,
    input  logic            i_ready,
    input  spq_pkg::t_status i_status,
    output spq_pkg::t_cmd   o_cmd
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   load;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign load    = (r_state == S_LOAD) && (!r_out_valid || i_ready);

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = accept;
        o_cmd.load   = load;
        if (accept) begin
            if (i_kind == KIND_PUSH) begin
                o_cmd.push   = !i_status.full;
                o_cmd.reject = i_status.full;
            end else begin
                o_cmd.pop    = !i_status.empty;
                o_cmd.reject = i_status.empty;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

[hw/rtl/spq_datapath.sv]
// ----------------------------------------------------------------------------
// spq_datapath
// Row of sorted cells with parallel compare, tail register and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spq_pkg::t_cmd                     i_cmd,
    input  spq_pkg::t_value                   i_new_value,
    output spq_pkg::t_status                  o_status,
    output logic [$clog2(DEPTH+1)-1:0]        o_count,
    output spq_pkg::t_value                   o_head_value,
    output spq_pkg::t_value                   o_tail_value,
    output logic [spq_pkg::COUNT_OUT_W-1:0]   o_entry_count,
    output logic                              o_is_empty,
    output logic                              o_rejected
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_value          r_entry [DEPTH];
    t_value          n_entry [DEPTH];
    logic [DEPTH-1:0] lt;
    logic [CW-1:0]   r_count, n_count;
    t_value          r_tail, n_tail;
    logic            r_rej;
    t_value          r_head_out, r_tail_out;
    logic [COUNT_OUT_W-1:0] r_count_out;
    logic            r_empty_out, r_rej_out;
    logic [31:0]     count_wide;
    logic            is_empty_now;

    // A cell holds a value that the new item must go in front of.
    // Equal values do not qualify, so a new item lands behind them.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_value from_prev;
        logic   sel;

        assign lt[i] = (CW'(i) < r_count) && (i_new_value < r_entry[i]);
        assign sel   = lt[i] || (CW'(i) == r_count);

        if (i == 0) begin : g_first
            assign from_prev = i_new_value;
        end else begin : g_rest
            assign from_prev = lt[i-1] ? r_entry[i-1] : i_new_value;
        end

        always_comb begin
            n_entry[i] = r_entry[i];
            if (i_cmd.push && sel) begin
                n_entry[i] = from_prev;
            end else if (i_cmd.pop) begin
                if (i < DEPTH - 1) begin
                    n_entry[i] = r_entry[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_entry[i] <= n_entry[i];
        end
    end

    always_comb begin
        n_count = r_count;
        n_tail  = r_tail;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
            if (lt == '0) begin
                n_tail = i_new_value;
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    assign is_empty_now = (r_count == '0);
    assign count_wide   = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail <= n_tail;
        if (i_cmd.accept) begin
            r_rej <= i_cmd.reject;
        end
        if (i_cmd.load) begin
            r_head_out  <= is_empty_now ? '1 : r_entry[0];
            r_tail_out  <= is_empty_now ? '1 : r_tail;
            r_count_out <= count_wide[COUNT_OUT_W-1:0];
            r_empty_out <= is_empty_now;
            r_rej_out   <= r_rej;
        end
    end

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = is_empty_now;
    assign o_count        = r_count;
    assign o_head_value   = r_head_out;
    assign o_tail_value   = r_tail_out;
    assign o_entry_count  = r_count_out;
    assign o_is_empty     = r_empty_out;
    assign o_rejected     = r_rej_out;

endmodule

[dv/tb_sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue: pushes and pops are
// tracked in a sorted shadow queue, and every status item is compared with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
    spq_pkg::t_value                 head;
    spq_pkg::t_value                 tail;
    logic [spq_pkg::COUNT_OUT_W-1:0] count;
    logic                            empty;
    logic                            rejected;
} queue_status_t;

class sorted_queue_tracker;
    localparam int DEPTH = spq_pkg::DEPTH_DEFAULT;
    localparam int PRINT_CAP = 40;

    spq_pkg::t_value held[$];
    queue_status_t   awaited[$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     pushes;
    int unsigned     pops;
    int unsigned     refused_pushes;
    int unsigned     refused_pops;
    int unsigned     full_hits;

    // Applies one accepted item to the shadow queue and records the status it
    // should produce.
    function void note_item(logic kind, spq_pkg::t_value value);
        queue_status_t want;
        int            pos;
        want.rejected = 1'b0;
        if (kind == spq_pkg::KIND_PUSH) begin
            if (held.size() >= DEPTH) begin
                want.rejected = 1'b1;
                refused_pushes++;
            end else begin
                // Equal values queue up behind the ones already stored.
                pos = held.size();
                while (pos > 0 && value < held[pos-1])
                    pos--;
                held.insert(pos, value);
                pushes++;
                if (held.size() == DEPTH)
                    full_hits++;
            end
        end else begin
            if (held.size() == 0) begin
                want.rejected = 1'b1;
                refused_pops++;
            end else begin
                void'(held.pop_front());
                pops++;
            end
        end
        if (held.size() == 0) begin
            want.head  = '1;
            want.tail  = '1;
            want.empty = 1'b1;
        end else begin
            want.head  = held[0];
            want.tail  = held[held.size()-1];
            want.empty = 1'b0;
        end
        want.count = spq_pkg::COUNT_OUT_W'(held.size());
        awaited.push_back(want);
    endfunction

    task report(string msg);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task check_status(queue_status_t got);
        queue_status_t want;
        if (awaited.size() == 0) begin
            report($sformatf("status item with no pending item (head %0d, count %0d)",
                             got.head, got.count));
            return;
        end
        want = awaited.pop_front();
        if (got.head !== want.head)
            report($sformatf("status %0d head_value got %0d expected %0d",
                             checked, got.head, want.head));
        if (got.tail !== want.tail)
            report($sformatf("status %0d tail_value got %0d expected %0d",
                             checked, got.tail, want.tail));
        if (got.count !== want.count)
            report($sformatf("status %0d entry_count got %0d expected %0d",
                             checked, got.count, want.count));
        if (got.empty !== want.empty)
            report($sformatf("status %0d is_empty got %b expected %b",
                             checked, got.empty, want.empty));
        if (got.rejected !== want.rejected)
            report($sformatf("status %0d rejected got %b expected %b",
                             checked, got.rejected, want.rejected));
        checked++;
    endtask
endclass

module tb_sorted_priority_queue;
    import spq_pkg::t_value;

    localparam int     RANDOM_ITEMS = 1728;
    localparam int     QUIET_TAIL   = 250;
    localparam int     HOLD_CYCLES  = 80;
    localparam int     STALL_LIMIT  = 2000;
    localparam t_value VAL_MAX      = 32'sh7FFF_FFFF;
    localparam t_value VAL_MIN      = 32'sh8000_0000;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic                            i_kind = spq_pkg::KIND_PUSH;
    t_value                          i_new_value = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    t_value                          o_head_value;
    t_value                          o_tail_value;
    logic [spq_pkg::COUNT_OUT_W-1:0] o_entry_count;
    logic                            o_is_empty;
    logic                            o_rejected;

    sorted_queue_tracker tracker = new;
    int unsigned         idle_cycles = 0;
    bit                  idle_enable = 1'b1;
    bit                  hold_request = 1'b0;

    sorted_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_new_value   (i_new_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_head_value  (o_head_value),
        .o_tail_value  (o_tail_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_rejected    (o_rejected)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Both handshakes are observed here, input first, so a prediction always
    // exists before the status it belongs to can be checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                tracker.note_item(i_kind, i_new_value);
            if (o_valid && i_ready)
                tracker.check_status({o_head_value, o_tail_value, o_entry_count,
                                      o_is_empty, o_rejected});
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random ready bursts, plus one long hold-off on request.
    initial begin
        while (!i_rst_n)
            @(negedge i_clk);
        forever begin
            if (hold_request) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (idle_enable && $urandom_range(0, 3) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high.
    task offer_item(input logic kind, input t_value value);
        i_kind      = kind;
        i_new_value = value;
        i_valid     = 1'b1;
        do
            @(posedge i_clk);
        while (!o_ready);
        @(negedge i_clk);
    endtask

    task sender_gap(input int cycles);
        i_valid     = 1'b0;
        i_kind      = 1'($urandom_range(0, 1));
        i_new_value = $urandom;
        repeat (cycles) @(negedge i_clk);
    endtask

    task wait_drained();
        i_valid = 1'b0;
        while (tracker.awaited.size() != 0)
            @(negedge i_clk);
    endtask

    // Mix of extremes, a narrow band that yields many equal values, and
    // full-range values.
    function automatic t_value pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return -1;
                    default: return 0;
                endcase
            end
            1, 2, 3: return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int     n;
        int     push_pct;
        logic   kind;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: pop on empty, fill with extremes and duplicates, push on
        // full, then a few pops.
        offer_item(spq_pkg::KIND_POP, 0);
        offer_item(spq_pkg::KIND_PUSH, VAL_MAX);
        offer_item(spq_pkg::KIND_PUSH, VAL_MIN);
        offer_item(spq_pkg::KIND_PUSH, -1);
        offer_item(spq_pkg::KIND_PUSH, 0);
        offer_item(spq_pkg::KIND_PUSH, 5);
        offer_item(spq_pkg::KIND_PUSH, 5);
        offer_item(spq_pkg::KIND_PUSH, -1);
        offer_item(spq_pkg::KIND_PUSH, VAL_MIN);
        for (n = 0; n < 8; n++)
            offer_item(spq_pkg::KIND_PUSH, $urandom);
        offer_item(spq_pkg::KIND_PUSH, 3);
        for (n = 0; n < 4; n++)
            offer_item(spq_pkg::KIND_POP, $urandom);
        wait_drained();

        push_pct = 50;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 125 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
                idle_enable = (n < RANDOM_ITEMS - QUIET_TAIL) &&
                              ($urandom_range(0, 3) != 0);
            end
            if (n >= RANDOM_ITEMS - QUIET_TAIL)
                idle_enable = 1'b0;
            if (n == 400)
                wait_drained();
            // The sender keeps offering while the receiver holds off, so the
            // block backs up and drops ready.
            if (n == 900)
                hold_request = 1'b1;
            kind = ($urandom_range(0, 99) < push_pct) ? spq_pkg::KIND_PUSH
                                                      : spq_pkg::KIND_POP;
            offer_item(kind, pick_value());
            if (idle_enable && $urandom_range(0, 3) == 0)
                sender_gap($urandom_range(1, 13));
        end
        i_valid = 1'b0;

        while (tracker.awaited.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.awaited.size() != 0)
            tracker.report($sformatf("%0d status items never arrived",
                                     tracker.awaited.size()));

        $display("Covered %0d pushes (%0d refused on full) and %0d pops (%0d refused on empty).",
                 tracker.pushes, tracker.refused_pushes, tracker.pops, tracker.refused_pops);
        $display("Queue filled up %0d times; %0d status items checked, %0d mismatches.",
                 tracker.full_hits, tracker.checked, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
